>>> src/pdlr_pkg.sv
package pdlr_pkg;

    // decoded sample width, Q1.23 plus headroom for +1.0
    localparam int SAMPLE_W = 25;
    localparam int RAW_W    = 32;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MONO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

    // sample format codes
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S24 = 3'd2;
    localparam logic [2:0] FMT_S32 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;

    localparam logic [2:0]            FORMAT_RESET = FMT_S16;
    localparam logic [CFG_DATA_W-1:0] STEP_RESET   = 28'd16777216;

    // results per input word are capped
    localparam int               CNT_W      = 5;
    localparam logic [CNT_W-1:0] RESULT_CAP = 5'd16;
    localparam logic [CNT_W-1:0] LAST_SLOT  = 5'd15;

    typedef struct packed {
        logic load;        // capture decoded sample of a new word
        logic issue;       // start one interpolation product
        logic hold;        // product uses current sample only
        logic commit;      // word done, current sample becomes previous
        logic clear_prev;  // packet end: previous sample cleared
    } lane_ctrl_t;

    function automatic logic signed [SAMPLE_W-1:0] decode_sample(
        input logic [2:0]       fmt,
        input logic [RAW_W-1:0] raw
    );
        logic signed [SAMPLE_W-1:0] res;
        logic [7:0]                 expo;
        logic [6:0]                 shamt;
        logic [23:0]                mag;
        begin
            expo  = raw[30:23];
            shamt = 7'd127 - expo[6:0];
            mag   = 24'd0;
            res   = '0;
            unique case (fmt)
                FMT_U8:  res = {{2{~raw[7]}}, raw[6:0], 16'd0};
                FMT_S16: res = {{2{raw[15]}}, raw[15:0], 7'd0};
                FMT_S24: res = {raw[23], raw[23:0]};
                FMT_S32: res = {raw[31], raw[31:8]};
                FMT_F32:
                begin
                    if (expo == 8'hff || expo == 8'h00)
                        mag = 24'd0;
                    else if (expo >= 8'd127)
                        mag = 24'h800000;
                    else
                        mag = {1'b1, raw[22:0]} >> shamt;
                    res = raw[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                end
                default: res = '0;
            endcase
            return res;
        end
    endfunction

endpackage

>>> src/pdlr_lane.sv
module pdlr_lane
    import pdlr_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic [2:0]                 fmt,
    input  logic [RAW_W-1:0]           raw,
    input  logic [FRAC_BITS-1:0]       frac,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic signed [SAMPLE_W-1:0] cur_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] base_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic signed [SAMPLE_W-1:0] base_next;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [FRAC_BITS:0]  weight;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [DIFF_W-1:0]   delta;
    logic signed [DIFF_W-1:0]   sum;

    // hold phases: base is the current sample, weight zero
    assign base_next = ctrl.hold ? cur_reg : prev_reg;
    assign diff      = DIFF_W'(cur_reg) - DIFF_W'(base_next);
    assign weight    = ctrl.hold ? '0 : $signed({1'b0, frac});
    assign prod_next = diff * weight;

    // floor shift of the product, then add the base
    assign delta  = DIFF_W'(prod_reg >>> FRAC_BITS);
    assign sum    = DIFF_W'(base_reg) + delta;
    assign result = sum[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            prev_reg <= ctrl.clear_prev ? '0 : cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cur_reg <= decode_sample(fmt, raw);
        end
        if (ctrl.issue)
        begin
            base_reg <= base_next;
            prod_reg <= prod_next;
        end
    end

endmodule

>>> src/pdlr_seq.sv
module pdlr_seq
    import pdlr_pkg::*;
#(
    parameter int FRAC_BITS    = 24,
    parameter int MAX_UPSAMPLE = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  packet_end,
    input  logic [CFG_DATA_W-1:0] rate_step,
    input  logic                  phase_clear,
    input  logic                  advance,
    output logic                  idle,
    output lane_ctrl_t            ctrl,
    output logic [FRAC_BITS-1:0]  frac,
    output logic                  last
);

    // phase holds up to one plus the largest step
    localparam int PW   = FRAC_BITS + 5;
    localparam int UP   = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
    localparam int DN   = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
    localparam int WW   = CFG_DATA_W + UP;
    localparam logic [PW-1:0] ONE = {{(PW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0] TWO = ONE << 1;
    localparam logic [PW-1:0] STEP_MIN =
        PW'(((64'd1 << FRAC_BITS) + 64'(MAX_UPSAMPLE) - 64'd1) / 64'(MAX_UPSAMPLE));

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INTERP = 2'd1;
    localparam logic [1:0] ST_HOLD   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PW-1:0]    phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             end_reg, end_next;
    logic             have_prev_reg, have_prev_next;

    logic [WW-1:0]    step_wide;
    logic [PW-1:0]    step_scaled;
    logic [PW-1:0]    step_eff;
    logic [PW-1:0]    phase_sum;
    logic             more_here;
    logic             more_after;

    assign step_wide   = (WW'(rate_step) << UP) >> DN;
    assign step_scaled = PW'(step_wide);
    assign step_eff    = (step_scaled < STEP_MIN) ? STEP_MIN : step_scaled;
    assign phase_sum   = phase_reg + step_eff;

    // lookahead for the last result of this word
    assign more_here  = phase_sum < ONE;
    assign more_after = (state_reg == ST_INTERP) && end_reg && (phase_sum < TWO);

    assign idle = (state_reg == ST_IDLE);
    assign frac = phase_reg[FRAC_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        have_prev_next = have_prev_reg;
        ctrl           = '0;
        last           = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    end_next  = packet_end;
                    cnt_next  = '0;
                    if (have_prev_reg)
                        state_next = ST_INTERP;
                    else if (packet_end)
                        state_next = ST_HOLD;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_INTERP, ST_HOLD:
            begin
                if (phase_reg < ONE)
                begin
                    if (cnt_reg < RESULT_CAP)
                    begin
                        if (advance)
                        begin
                            ctrl.issue = 1'b1;
                            ctrl.hold  = (state_reg == ST_HOLD);
                            cnt_next   = cnt_reg + CNT_W'(1);
                            phase_next = phase_sum;
                            last       = (cnt_reg == LAST_SLOT) || !(more_here || more_after);
                        end
                    end
                    else
                    begin
                        // over the cap: phase still advances, nothing emitted
                        phase_next = phase_sum;
                    end
                end
                else
                begin
                    phase_next = phase_reg - ONE;
                    state_next = (state_reg == ST_INTERP && end_reg) ? ST_HOLD : ST_DONE;
                end
            end
            ST_DONE:
            begin
                ctrl.commit     = 1'b1;
                ctrl.clear_prev = end_reg;
                have_prev_next  = !end_reg;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (phase_clear)
            phase_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            end_reg       <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
            have_prev_reg <= have_prev_next;
        end
    end

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.issue |-> (phase_reg < ONE) && (cnt_reg < RESULT_CAP))
        else $error("issue outside phase window or over cap");

    a_cnt_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RESULT_CAP)
        else $error("result counter past cap");

    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> (state_reg == ST_IDLE) && !ctrl.issue)
        else $error("commit did not return to idle");

endmodule

>>> src/pcm_decode_linear_resampler.sv
// PCM decoder with linear-interpolation rate conversion to 48 kHz. Each input
// word is one stereo source frame (two raw sample words plus a packet-end mark
// on s_tlast); both samples are decoded to Q1.23 by sample_format (u8, s16,
// s24, s32, float32 clamped to +-1.0, anything else gives zero), the right
// lane taking the left word when mono_source is set. A phase accumulator then
// steps by rate_step and one output word is produced per phase that falls
// between the previous and the current frame; at a packet end the last frame
// is repeated for the remaining phases and the phase carries into the next
// packet. At most 16 output words follow one input word, m_tlast marking the
// final one. One input word is taken while the sequencer is idle and
// occupies it for all of its phase steps (emitted or not), for each phase
// loop it exits (0, 1 or 2) and for a final commit, so no new word is taken
// before the last one is done; a single phase adder in the sequencer handles
// one step per cycle, so output words come at up to one per cycle, and an
// output stall holds the sequencer. Results pass two lane stages (multiply,
// then add into the output register). Writing rate_step clears the phase;
// configuration is to be written while idle only; the block does not enforce it.
module pcm_decode_linear_resampler
    import pdlr_pkg::*;
#(
    parameter int FRAC_BITS    = 24,
    parameter int MAX_UPSAMPLE = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // raw_left[31:0], raw_right[63:32]
    input  logic                  s_tlast,   // packet_end

    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // out_left[24:0], out_right[49:25], zero pad
    output logic                  m_tlast    // last_of_run
);

    // configuration registers
    logic [2:0]            fmt_reg;
    logic                  mono_reg;
    logic [CFG_DATA_W-1:0] step_reg;
    logic                  phase_clear;

    // sequencer to lanes
    lane_ctrl_t            lane_ctrl;
    logic [FRAC_BITS-1:0]  frac;
    logic                  issue_last;
    logic                  seq_idle;
    logic                  accept;
    logic                  stall;

    // product stage valid and output register
    logic                  a_valid_reg;
    logic                  a_last_reg;
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic [SAMPLE_W-1:0]   out_left_reg;
    logic [SAMPLE_W-1:0]   out_right_reg;

    logic [RAW_W-1:0]           raw_right_sel;
    logic signed [SAMPLE_W-1:0] left_res;
    logic signed [SAMPLE_W-1:0] right_res;

    assign phase_clear = cfg_we && (cfg_addr == REG_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FORMAT_RESET;
            mono_reg <= 1'b0;
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FORMAT: fmt_reg  <= cfg_data[2:0];
                REG_MONO:   mono_reg <= cfg_data[0];
                REG_STEP:   step_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // input side: one frame at a time, taken whenever the sequencer is idle
    assign s_tready = seq_idle;
    assign accept   = s_tvalid && s_tready;

    // output register full and not drained: freeze the lane pipeline
    assign stall = out_valid_reg && !m_tready;

    pdlr_seq #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .packet_end  (s_tlast),
        .rate_step   (step_reg),
        .phase_clear (phase_clear),
        .advance     (!stall),
        .idle        (seq_idle),
        .ctrl        (lane_ctrl),
        .frac        (frac),
        .last        (issue_last)
    );

    // mono source: the right lane decodes the left word too
    assign raw_right_sel = mono_reg ? s_tdata[31:0] : s_tdata[63:32];

    pdlr_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .fmt    (fmt_reg),
        .raw    (s_tdata[31:0]),
        .frac   (frac),
        .result (left_res)
    );

    pdlr_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .fmt    (fmt_reg),
        .raw    (raw_right_sel),
        .frac   (frac),
        .result (right_res)
    );

    // merge: both lane sums and the last flag go into one output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            a_last_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (!stall)
        begin
            a_valid_reg   <= lane_ctrl.issue;
            a_last_reg    <= issue_last;
            out_valid_reg <= a_valid_reg;
            out_last_reg  <= a_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall && a_valid_reg)
        begin
            out_left_reg  <= left_res;
            out_right_reg <= right_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_right_reg, out_left_reg};

    a_no_issue_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !lane_ctrl.issue)
        else $error("product issued while output stalled");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while waiting");

    a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tlast |-> m_tvalid)
        else $error("m_tlast without m_tvalid");

endmodule

>>> tb/tb_pcm_decode_linear_resampler.sv
`timescale 1ns / 1ps

// One expected output word of the resampler.
typedef struct packed {
    logic signed [pdlr_pkg::SAMPLE_W-1:0] left;
    logic signed [pdlr_pkg::SAMPLE_W-1:0] right;
    logic                                 last;
} frame_word_t;

// Scoreboard: keeps its own copy of the decoder/resampler state, turns each
// accepted source frame into the output words it should cause, and checks
// every output word against the oldest one still waiting.
class resampler_scoreboard;

    localparam int     FRAC_BITS    = 24;
    localparam int     MAX_UPSAMPLE = 8;
    localparam longint PHASE_ONE    = longint'(1) << FRAC_BITS;
    localparam longint STEP_FLOOR   = (PHASE_ONE + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;

    logic [2:0]  fmt;
    logic        mono;
    logic [27:0] rate;
    longint      phase;
    longint      prev_l;
    longint      prev_r;
    bit          held;

    frame_word_t expected_words[$];
    int          errors;

    function new();
        fmt             = pdlr_pkg::FORMAT_RESET;
        mono            = 1'b0;
        rate            = pdlr_pkg::STEP_RESET;
        phase           = 0;
        prev_l          = 0;
        prev_r          = 0;
        held            = 0;
        errors          = 0;
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function int pending();
        return expected_words.size();
    endfunction

    function void set_reg(logic [pdlr_pkg::CFG_IDX_W-1:0] idx,
                          logic [pdlr_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            pdlr_pkg::REG_FORMAT: fmt = val[2:0];
            pdlr_pkg::REG_MONO:   mono = val[0];
            pdlr_pkg::REG_STEP:
            begin
                rate  = val;
                phase = 0;
            end
            default: ;
        endcase
    endfunction

    // raw word -> Q1.23
    function longint decode(logic [31:0] raw);
        logic [7:0]  ex;
        logic [23:0] mag;
        int          sh;
        ex  = raw[30:23];
        mag = '0;
        case (fmt)
            pdlr_pkg::FMT_U8:  return (longint'(raw[7:0]) - 128) * 65536;
            pdlr_pkg::FMT_S16: return longint'($signed(raw[15:0])) * 128;
            pdlr_pkg::FMT_S24: return longint'($signed(raw[23:0]));
            pdlr_pkg::FMT_S32: return longint'($signed(raw)) >>> 8;
            pdlr_pkg::FMT_F32:
            begin
                if (ex == 8'hff || ex == 8'h00)
                    return 0;
                if (ex >= 8'd127)
                    mag = 24'h800000;
                else
                begin
                    sh = 127 - int'(ex);
                    mag = (sh >= 24) ? 24'd0 : ({1'b1, raw[22:0]} >> sh);
                end
                return raw[31] ? -longint'(mag) : longint'(mag);
            end
            default: return 0;
        endcase
    endfunction

    function void push_word(ref frame_word_t run[$], input longint l, input longint r);
        frame_word_t w;
        if (run.size() >= int'(pdlr_pkg::RESULT_CAP))
            return;
        w.left  = l[pdlr_pkg::SAMPLE_W-1:0];
        w.right = r[pdlr_pkg::SAMPLE_W-1:0];
        w.last  = 1'b0;
        run = {run, w};
    endfunction

    function void note_input(logic [31:0] raw_l, logic [31:0] raw_r, logic pend);
        longint      step;
        longint      cl;
        longint      cr;
        longint      l;
        longint      r;
        frame_word_t run[$];
        step = (longint'(rate) < STEP_FLOOR) ? STEP_FLOOR : longint'(rate);
        cl   = decode(raw_l);
        cr   = mono ? cl : decode(raw_r);
        if (held)
        begin
            while (phase < PHASE_ONE)
            begin
                l = prev_l + (((cl - prev_l) * phase) >>> FRAC_BITS);
                r = prev_r + (((cr - prev_r) * phase) >>> FRAC_BITS);
                push_word(run, l, r);
                phase += step;
            end
            phase -= PHASE_ONE;
        end
        if (pend)
        begin
            while (phase < PHASE_ONE)
            begin
                push_word(run, cl, cr);
                phase += step;
            end
            phase -= PHASE_ONE;
            held   = 0;
            prev_l = 0;
            prev_r = 0;
        end
        else
        begin
            prev_l = cl;
            prev_r = cr;
            held   = 1;
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        expected_words = {expected_words, run};
    endfunction

    task check_result(logic signed [pdlr_pkg::SAMPLE_W-1:0] l,
                      logic signed [pdlr_pkg::SAMPLE_W-1:0] r,
                      logic last);
        frame_word_t w;
        if (expected_words.size() == 0)
        begin
            report($sformatf("unexpected word left %0d right %0d last %0b", l, r, last));
            return;
        end
        w = expected_words.pop_front();
        if (l !== w.left)
            report($sformatf("out_left %0d, want %0d", l, w.left));
        if (r !== w.right)
            report($sformatf("out_right %0d, want %0d", r, w.right));
        if (last !== w.last)
            report($sformatf("last_of_run %0b, want %0b", last, w.last));
    endtask

endclass

module tb_pcm_decode_linear_resampler;

    import pdlr_pkg::*;

    // codes the package has no name for
    localparam logic [2:0]           FMT_NONE = 3'd5;      // unsupported, decodes to zero
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;      // no such register

    // rate_step values, Q4.24
    localparam logic [27:0] STEP_ONE  = 28'd16777216;      // 48 kHz source
    localparam logic [27:0] STEP_LOW  = 28'd2097152;       // 6 kHz source, 8x upsample
    localparam logic [27:0] STEP_HIGH = 28'd134217728;     // 384 kHz source, 8x down
    localparam logic [27:0] STEP_44K1 = 28'd15414067;      // 44.1 kHz source

    // the sequencer steps through every phase of a word, then two lane stages;
    // SETTLE_CYCLES covers a word that yields nothing after the last output
    localparam int SETTLE_CYCLES = 48;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int RAND_ITEMS    = 60;
    localparam int PHASE_ITEMS   = 20;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [27:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    resampler_scoreboard sb;

    // idle knobs: when set, that side runs flat out
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;

    int out_wait = 0;
    int out_pick;

    pcm_decode_linear_resampler dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic int draw_gap(bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Output side: check every accepted word, then draw a stall from draw_gap
    // before taking the next one. Values read here are the ones present at the
    // edge; ours and the block's updates land afterwards.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata[24:0], m_tdata[49:25], m_tlast);
            out_pick = draw_gap(out_calm);
            if (out_pick == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                out_wait <= out_pick;
            end
        end
        else if (out_wait > 0)
        begin
            out_wait <= out_wait - 1;
            if (out_wait == 1)
                m_tready <= 1'b1;
        end
        else
            m_tready <= 1'b1;
    end

    // Sends a source word; called just after the clock rises. With no gap the
    // new word goes straight onto the bus in the step where the last one
    // was taken, so tvalid stays high without a second assignment.
    task automatic send_frame(logic [31:0] raw_l, logic [31:0] raw_r, logic pend);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_r, raw_l};
        s_tlast  <= pend;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(raw_l, raw_r, pend);
    endtask

    // Register write: one cycle of cfg_we, then a wait with the enable low, so
    // that the next write never lowers and raises the enable in the same step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Drop tvalid, wait for every expected word, then let the sequencer
    // finish a word that may yield nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly in-range floats so the shift path is exercised; sometimes
    // any bit pattern (NaN, inf, denormals, huge values).
    function automatic logic [31:0] rand_raw(logic [2:0] fmt);
        logic [31:0] v;
        v = $urandom();
        if (fmt == FMT_F32 && $urandom_range(0, 3) != 0)
            v[30:23] = 8'($urandom_range(100, 129));
        return v;
    endfunction

    function automatic logic [27:0] rand_step();
        case ($urandom_range(0, 4))
            0:       return 28'($urandom_range(0, int'(STEP_LOW)));   // raised to 1/8
            1:       return 28'($urandom_range(int'(STEP_LOW), int'(STEP_ONE)));
            2:       return 28'($urandom_range(int'(STEP_ONE), int'(STEP_HIGH)));
            3:       return STEP_44K1;
            default: return 28'($urandom_range(int'(STEP_LOW), int'(STEP_HIGH)));
        endcase
    endfunction

    // A packet of 1..8 frames closed by packet_end; one in eight is noise
    // with packet_end drawn per frame. Returns the number of frames sent.
    task automatic rand_packet(logic [2:0] fmt, output int sent);
        int len;
        bit noise;
        len   = $urandom_range(1, 8);
        noise = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (noise)
                send_frame(rand_raw(fmt), rand_raw(fmt), 1'($urandom_range(0, 1)));
            else
                send_frame(rand_raw(fmt), rand_raw(fmt), i == len - 1);
        end
        sent = len;
    endtask

    initial
    begin
        int         rand_items;
        int         phase_items;
        int         sent;
        int         phases;
        logic [2:0] fmt;

        sb = new();
        rand_items = 0;
        phases     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // --- directed part ---

        // reset settings: s16 stereo at 1.0; extremes and ignored high bits
        send_frame(32'h0000_7fff, 32'h0000_8000, 1'b0);
        send_frame(32'hffff_0000, 32'habcd_ffff, 1'b0);
        send_frame(32'h1234_0001, 32'h0000_0000, 1'b0);
        send_frame(32'h0000_8000, 32'h0000_7fff, 1'b1);
        settle();

        // u8; the write to a missing register must change nothing
        write_reg(REG_NONE, 28'hfff_ffff);
        write_reg(REG_FORMAT, {25'd0, FMT_U8});
        send_frame(32'h0000_0000, 32'h0000_00ff, 1'b1);     // one-frame packet
        send_frame(32'h0000_0080, 32'h0000_007f, 1'b0);
        send_frame(32'ha5a5_a57f, 32'h5a5a_5a80, 1'b1);
        settle();

        // s24, mono, zero step (raised to the 8x floor)
        write_reg(REG_FORMAT, {25'd0, FMT_S24});
        write_reg(REG_MONO, 28'd1);
        write_reg(REG_STEP, 28'd0);
        send_frame(32'h007f_ffff, 32'h0000_0000, 1'b0);
        send_frame(32'hff80_0000, 32'h007f_ffff, 1'b0);
        send_frame(32'h0000_0001, 32'h0080_0000, 1'b1);
        settle();

        // s32 stereo, fastest source: most frames yield nothing
        write_reg(REG_FORMAT, {25'd0, FMT_S32});
        write_reg(REG_MONO, 28'd0);
        write_reg(REG_STEP, STEP_HIGH);
        send_frame(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_frame(32'hffff_ffff, 32'h0000_00ff, 1'b0);
        send_frame(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_frame(32'h0000_0000, 32'hffff_ff00, 1'b1);
        settle();

        // float32 at 8x upsample: clamp, NaN, infinities, denormals,
        // shifts at the edge of the fraction
        write_reg(REG_FORMAT, {25'd0, FMT_F32});
        write_reg(REG_STEP, STEP_LOW);
        send_frame(32'h3f80_0000, 32'hbf80_0000, 1'b0);     // +1.0, -1.0
        send_frame(32'h4000_0000, 32'h3f00_0000, 1'b0);     // 2.0, 0.5
        send_frame(32'h7fc0_0000, 32'h7f80_0000, 1'b0);     // NaN, +inf
        send_frame(32'hff80_0000, 32'h0000_0001, 1'b0);     // -inf, denormal
        send_frame(32'h3380_0000, 32'h3400_0000, 1'b0);     // shifted out, lsb
        send_frame(32'hbf40_0000, 32'h3eaa_aaab, 1'b0);     // -0.75, 1/3
        send_frame(32'h807f_ffff, 32'hc2c8_0000, 1'b0);     // -denormal, -100
        send_frame(32'h3f7f_ffff, 32'hbf7f_ffff, 1'b1);     // just below +-1
        settle();

        // unsupported format at 44.1 kHz
        write_reg(REG_FORMAT, {25'd0, FMT_NONE});
        write_reg(REG_STEP, STEP_44K1);
        send_frame(32'hffff_ffff, 32'h7fff_ffff, 1'b0);
        send_frame(32'h1234_5678, 32'h8765_4321, 1'b1);
        settle();

        // --- random part ---
        // Each phase draws a new setting; the step is rewritten only half
        // the time so the phase also carries across settings.
        while (rand_items < RAND_ITEMS && phases < 20)
        begin
            settle();
            fmt = 3'($urandom_range(0, 5));
            write_reg(REG_FORMAT, {25'd0, fmt});
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_MONO, 28'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_STEP, rand_step());
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_NONE, 28'($urandom()));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                in_calm  = ($urandom_range(0, 4) == 0);
                out_calm = ($urandom_range(0, 4) == 0);
                rand_packet(fmt, sent);
                phase_items += sent;
            end
            rand_items += phase_items;
            phases++;
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("pcm_decode_linear_resampler regression: pass");
        else
            $display("pcm_decode_linear_resampler regression: fail");
        $finish;
    end

    // hard stop in case the block hangs
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("pcm_decode_linear_resampler regression: fail");
        $finish;
    end

endmodule
